// ===== design/jdm_pkg.sv =====
`timescale 1ns / 1ps

package jdm_pkg;

    // Grid size
    localparam int ROW_COUNT    = 5;
    localparam int COLUMN_COUNT = 8;
    localparam int ROW_W        = (ROW_COUNT > 2) ? $clog2(ROW_COUNT) : 1;
    localparam int COL_W        = (COLUMN_COUNT > 2) ? $clog2(COLUMN_COUNT) : 1;
    localparam int POS_OUT_W    = 3;
    localparam int PATTERN_W    = 8;
    // Wide enough for the column, for the port width and for the value 8
    localparam int COLX_W       = (COL_W > 4) ? COL_W : 4;
    localparam int ROWX_W       = (ROW_W > POS_OUT_W) ? ROW_W : POS_OUT_W;

    localparam logic [COL_W-1:0] COL_MAX = COL_W'(COLUMN_COUNT - 1);
    localparam logic [ROW_W-1:0] ROW_MAX = ROW_W'(ROW_COUNT - 1);

    // Samples and timers
    localparam int SAMPLE_W  = 10;
    localparam int TIMER_W   = 11;
    localparam int CFG_IDX_W = 2;

    localparam logic [TIMER_W-1:0] TICK_MS = TIMER_W'(100);

    // Zone edges, X axis
    localparam logic [SAMPLE_W-1:0] X_FAST_LO = SAMPLE_W'(49);
    localparam logic [SAMPLE_W-1:0] X_FAST_HI = SAMPLE_W'(899);
    localparam logic [SAMPLE_W-1:0] X_MID_LO  = SAMPLE_W'(225);
    localparam logic [SAMPLE_W-1:0] X_MID_HI  = SAMPLE_W'(658);
    localparam logic [SAMPLE_W-1:0] X_SLOW_LO = SAMPLE_W'(379);
    localparam logic [SAMPLE_W-1:0] X_SLOW_HI = SAMPLE_W'(408);

    // Zone edges, Y axis
    localparam logic [SAMPLE_W-1:0] Y_FAST_LO = SAMPLE_W'(134);
    localparam logic [SAMPLE_W-1:0] Y_FAST_HI = SAMPLE_W'(797);
    localparam logic [SAMPLE_W-1:0] Y_MID_LO  = SAMPLE_W'(220);
    localparam logic [SAMPLE_W-1:0] Y_MID_HI  = SAMPLE_W'(696);
    localparam logic [SAMPLE_W-1:0] Y_SLOW_LO = SAMPLE_W'(320);
    localparam logic [SAMPLE_W-1:0] Y_SLOW_HI = SAMPLE_W'(595);

    // Threshold reset values
    localparam logic [SAMPLE_W-1:0] X_LEFT_RST  = SAMPLE_W'(386);
    localparam logic [SAMPLE_W-1:0] X_RIGHT_RST = SAMPLE_W'(447);
    localparam logic [SAMPLE_W-1:0] Y_UP_RST    = SAMPLE_W'(416);
    localparam logic [SAMPLE_W-1:0] Y_DOWN_RST  = SAMPLE_W'(480);

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_X_LEFT  = 2'd0,
        CFG_X_RIGHT = 2'd1,
        CFG_Y_UP    = 2'd2,
        CFG_Y_DOWN  = 2'd3
    } t_cfg_reg;

    typedef enum logic [1:0] {
        PER_100  = 2'd0,
        PER_250  = 2'd1,
        PER_500  = 2'd2,
        PER_1000 = 2'd3
    } t_period;

    typedef struct packed {
        t_period period;
        logic    step_inc;
        logic    step_dec;
    } t_axis_cmd;

    typedef struct packed {
        t_axis_cmd x;
        t_axis_cmd y;
    } t_dec_item;

    function automatic t_period x_zone(input logic [SAMPLE_W-1:0] s);
        t_period p;
        if (s < X_FAST_LO || s > X_FAST_HI) begin
            p = PER_100;
        end else if (s <= X_MID_LO || s >= X_MID_HI) begin
            p = PER_250;
        end else if (s <= X_SLOW_LO || s >= X_SLOW_HI) begin
            p = PER_500;
        end else begin
            p = PER_1000;
        end
        return p;
    endfunction

    // The 250 ms band takes in samples 134 and 797 on this axis
    function automatic t_period y_zone(input logic [SAMPLE_W-1:0] s);
        t_period p;
        if (s < Y_FAST_LO || s > Y_FAST_HI) begin
            p = PER_100;
        end else if (s <= Y_MID_LO || s >= Y_MID_HI) begin
            p = PER_250;
        end else if (s <= Y_SLOW_LO || s >= Y_SLOW_HI) begin
            p = PER_500;
        end else begin
            p = PER_1000;
        end
        return p;
    endfunction

    function automatic logic [TIMER_W-1:0] period_ms(input t_period p);
        logic [TIMER_W-1:0] v;
        case (p)
            PER_100:  v = TIMER_W'(100);
            PER_250:  v = TIMER_W'(250);
            PER_500:  v = TIMER_W'(500);
            PER_1000: v = TIMER_W'(1000);
            default:  v = TIMER_W'(1000);
        endcase
        return v;
    endfunction

    function automatic logic [PATTERN_W-1:0] col_pattern(input logic [COL_W-1:0] c);
        logic [COLX_W-1:0]    cx;
        logic [PATTERN_W-1:0] pat;
        cx = COLX_W'(c);
        if (cx < COLX_W'(PATTERN_W)) begin
            pat = PATTERN_W'(1) << cx[2:0];
        end else begin
            pat = '0;
        end
        return pat;
    endfunction

    function automatic logic [POS_OUT_W-1:0] col_out(input logic [COL_W-1:0] c);
        logic [COLX_W-1:0] cx;
        cx = COLX_W'(c);
        return cx[POS_OUT_W-1:0];
    endfunction

    function automatic logic [POS_OUT_W-1:0] row_out(input logic [ROW_W-1:0] r);
        logic [ROWX_W-1:0] rx;
        rx = ROWX_W'(r);
        return rx[POS_OUT_W-1:0];
    endfunction

endpackage

// ===== design/jdm_in_if.sv =====
`timescale 1ns / 1ps

interface jdm_in_if import jdm_pkg::*; ();
    logic                valid;
    logic                ready;
    logic [SAMPLE_W-1:0] x_sample;
    logic [SAMPLE_W-1:0] y_sample;

    modport source (output valid, output x_sample, output y_sample, input ready);
    modport sink   (input valid, input x_sample, input y_sample, output ready);
endinterface

// ===== design/jdm_out_if.sv =====
`timescale 1ns / 1ps

interface jdm_out_if import jdm_pkg::*; ();
    logic                 valid;
    logic                 ready;
    logic [POS_OUT_W-1:0] dot_column;
    logic [POS_OUT_W-1:0] dot_row;
    logic [PATTERN_W-1:0] column_pattern;

    modport source (output valid, output dot_column, output dot_row,
                    output column_pattern, input ready);
    modport sink   (input valid, input dot_column, input dot_row,
                    input column_pattern, output ready);
endinterface

// ===== design/joystick_dot_mover.sv =====
`timescale 1ns / 1ps

// Joystick dot mover: one input transfer per 100 ms control tick.
// Input channel i_in carries x_sample and y_sample (10 bits each); output
// channel o_out returns dot_column, dot_row and the one-hot column_pattern,
// exactly one result for every tick taken.
// Configuration: i_cfg_we with i_cfg_index 0..3 writes the X left, X right,
// Y up and Y down limits from i_cfg_data; write only while no tick is in flight.
// Stages: the decode register loads at the input transfer and the result
// register when that item transfers into the update stage, which a
// stalled receiver can hold off. Throughput: one tick per cycle while o_out
// is ready, set by the timer/position update feeding back on itself.
// Reset (synchronous, i_rst_n low): dot at column 0, row 0, both axis timers
// cleared, limits back to 386/447/416/480, both pipeline stages empty.
// When the receiver stalls, the result holds on o_out and the input register
// still takes one more tick; i_in.ready drops only when both stages are full.
module joystick_dot_mover import jdm_pkg::*; (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_cfg_we,
    input  logic [CFG_IDX_W-1:0] i_cfg_index,
    input  logic [SAMPLE_W-1:0]  i_cfg_data,
    jdm_in_if.sink               i_in,
    jdm_out_if.source            o_out
);

    logic      dec_valid;
    logic      upd_ready;
    t_dec_item dec_item;

    jdm_decode u_decode (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .i_valid     (i_in.valid),
        .o_ready     (i_in.ready),
        .i_x_sample  (i_in.x_sample),
        .i_y_sample  (i_in.y_sample),
        .o_valid     (dec_valid),
        .i_ready     (upd_ready),
        .o_item      (dec_item)
    );

    jdm_update u_update (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_valid          (dec_valid),
        .o_ready          (upd_ready),
        .i_item           (dec_item),
        .o_valid          (o_out.valid),
        .i_ready          (o_out.ready),
        .o_dot_column     (o_out.dot_column),
        .o_dot_row        (o_out.dot_row),
        .o_column_pattern (o_out.column_pattern)
    );

endmodule

// ===== design/jdm_decode.sv =====
`timescale 1ns / 1ps

module jdm_decode import jdm_pkg::*; (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_cfg_we,
    input  logic [CFG_IDX_W-1:0] i_cfg_index,
    input  logic [SAMPLE_W-1:0]  i_cfg_data,
    input  logic                 i_valid,
    output logic                 o_ready,
    input  logic [SAMPLE_W-1:0]  i_x_sample,
    input  logic [SAMPLE_W-1:0]  i_y_sample,
    output logic                 o_valid,
    input  logic                 i_ready,
    output t_dec_item            o_item
);

    logic [SAMPLE_W-1:0] r_x_left;
    logic [SAMPLE_W-1:0] r_x_right;
    logic [SAMPLE_W-1:0] r_y_up;
    logic [SAMPLE_W-1:0] r_y_down;
    logic                r_valid;
    t_dec_item           r_item;
    t_dec_item           n_item;
    logic                in_xfer;

    assign o_ready = !r_valid || i_ready;
    assign in_xfer = i_valid && o_ready;
    assign o_valid = r_valid;
    assign o_item  = r_item;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_x_left  <= X_LEFT_RST;
            r_x_right <= X_RIGHT_RST;
            r_y_up    <= Y_UP_RST;
            r_y_down  <= Y_DOWN_RST;
        end else if (i_cfg_we) begin
            case (t_cfg_reg'(i_cfg_index))
                CFG_X_LEFT:  r_x_left  <= i_cfg_data;
                CFG_X_RIGHT: r_x_right <= i_cfg_data;
                CFG_Y_UP:    r_y_up    <= i_cfg_data;
                CFG_Y_DOWN:  r_y_down  <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // Lower-limit move wins when the limits are crossed
    always_comb begin
        n_item.x.period   = x_zone(i_x_sample);
        n_item.x.step_inc = i_x_sample < r_x_left;
        n_item.x.step_dec = !(i_x_sample < r_x_left) && (i_x_sample > r_x_right);
        n_item.y.period   = y_zone(i_y_sample);
        n_item.y.step_inc = i_y_sample < r_y_up;
        n_item.y.step_dec = !(i_y_sample < r_y_up) && (i_y_sample > r_y_down);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_ready) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_xfer) begin
            r_item <= n_item;
        end
    end

endmodule

// ===== design/jdm_update.sv =====
`timescale 1ns / 1ps

module jdm_update import jdm_pkg::*; (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_valid,
    output logic                 o_ready,
    input  t_dec_item            i_item,
    output logic                 o_valid,
    input  logic                 i_ready,
    output logic [POS_OUT_W-1:0] o_dot_column,
    output logic [POS_OUT_W-1:0] o_dot_row,
    output logic [PATTERN_W-1:0] o_column_pattern
);

    logic                 r_out_valid;
    logic [COL_W-1:0]     r_col;
    logic [ROW_W-1:0]     r_row;
    logic [TIMER_W-1:0]   r_x_timer;
    logic [TIMER_W-1:0]   r_y_timer;
    logic [PATTERN_W-1:0] r_pattern;
    logic [COL_W-1:0]     n_col;
    logic [ROW_W-1:0]     n_row;
    logic [TIMER_W-1:0]   n_x_timer;
    logic [TIMER_W-1:0]   n_y_timer;
    logic [TIMER_W-1:0]   x_sum;
    logic [TIMER_W-1:0]   y_sum;
    logic                 x_due;
    logic                 y_due;
    logic                 xfer;

    assign o_ready = !r_out_valid || i_ready;
    assign xfer    = i_valid && o_ready;

    assign x_sum = r_x_timer + TICK_MS;
    assign y_sum = r_y_timer + TICK_MS;
    assign x_due = x_sum >= period_ms(i_item.x.period);
    assign y_due = y_sum >= period_ms(i_item.y.period);

    always_comb begin
        n_col     = r_col;
        n_x_timer = x_sum;
        if (x_due) begin
            n_x_timer = '0;
            if (i_item.x.step_inc && r_col != COL_MAX) begin
                n_col = r_col + COL_W'(1);
            end else if (i_item.x.step_dec && r_col != '0) begin
                n_col = r_col - COL_W'(1);
            end
        end
    end

    always_comb begin
        n_row     = r_row;
        n_y_timer = y_sum;
        if (y_due) begin
            n_y_timer = '0;
            if (i_item.y.step_inc && r_row != ROW_MAX) begin
                n_row = r_row + ROW_W'(1);
            end else if (i_item.y.step_dec && r_row != '0) begin
                n_row = r_row - ROW_W'(1);
            end
        end
    end

    // Position registers double as the result payload: they move only on a transfer
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
            r_col       <= '0;
            r_row       <= '0;
            r_x_timer   <= '0;
            r_y_timer   <= '0;
        end else begin
            if (o_ready) begin
                r_out_valid <= i_valid;
            end
            if (xfer) begin
                r_col     <= n_col;
                r_row     <= n_row;
                r_x_timer <= n_x_timer;
                r_y_timer <= n_y_timer;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (xfer) begin
            r_pattern <= col_pattern(n_col);
        end
    end

    assign o_valid          = r_out_valid;
    assign o_dot_column     = col_out(r_col);
    assign o_dot_row        = row_out(r_row);
    assign o_column_pattern = r_pattern;

    a_x_timer_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_x_timer <= TIMER_W'(1000))
        else $error("x timer above 1000");

    a_y_timer_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_y_timer <= TIMER_W'(1000))
        else $error("y timer above 1000");

    a_pos_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_col <= COL_MAX && r_row <= ROW_MAX)
        else $error("dot outside grid");

    a_state_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !xfer |=> $stable(r_col) && $stable(r_row) && $stable(r_x_timer)
                  && $stable(r_y_timer))
        else $error("state moved without a transfer");

    a_pattern_match: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid |-> r_pattern == col_pattern(r_col))
        else $error("column pattern does not match column");

endmodule

// ===== sim/dot_track_checker.sv =====
`timescale 1ns / 1ps

module dot_track_checker import jdm_pkg::*; (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_cfg_we,
    input  logic [CFG_IDX_W-1:0] i_cfg_index,
    input  logic [SAMPLE_W-1:0]  i_cfg_data,
    jdm_in_if                    i_in_mon,
    jdm_out_if                   i_out_mon,
    output int                   o_fail_count,
    output int                   o_pending
);

    typedef struct packed {
        logic [2:0] column;
        logic [2:0] row;
        logic [7:0] pattern;
    } t_dot_result;

    t_dot_result expected_dots[$];

    logic [SAMPLE_W-1:0] x_left;
    logic [SAMPLE_W-1:0] x_right;
    logic [SAMPLE_W-1:0] y_up;
    logic [SAMPLE_W-1:0] y_down;
    logic [10:0]         x_ms;
    logic [10:0]         y_ms;
    int unsigned         col_pos;
    int unsigned         row_pos;

    task automatic report_mismatch(input string msg);
        $display("MISMATCH @%0t: %s", $time, msg);
        o_fail_count++;
    endtask

    // Distance from center picks the repeat period of each axis
    function automatic t_period x_band(input logic [SAMPLE_W-1:0] s);
        if (s < 49 || s > 899) return PER_100;
        if (s <= 225 || s >= 658) return PER_250;
        if (s <= 379 || s >= 408) return PER_500;
        return PER_1000;
    endfunction

    // 134 and 797 fall in the 250 ms band
    function automatic t_period y_band(input logic [SAMPLE_W-1:0] s);
        if (s < 134 || s > 797) return PER_100;
        if (s <= 220 || s >= 696) return PER_250;
        if (s <= 320 || s >= 595) return PER_500;
        return PER_1000;
    endfunction

    function automatic logic [10:0] band_ms(input t_period p);
        case (p)
            PER_100:  return 11'd100;
            PER_250:  return 11'd250;
            PER_500:  return 11'd500;
            default:  return 11'd1000;
        endcase
    endfunction

    function automatic t_dot_result advance_dot(input logic [SAMPLE_W-1:0] xs,
                                                input logic [SAMPLE_W-1:0] ys);
        t_dot_result r;
        logic [10:0] xt;
        logic [10:0] yt;
        xt = x_ms + 11'd100;
        yt = y_ms + 11'd100;
        if (xt >= band_ms(x_band(xs))) begin
            x_ms = '0;
            // lower limit wins when the limits are crossed
            if (xs < x_left) begin
                if (col_pos < COLUMN_COUNT - 1) col_pos++;
            end else if (xs > x_right) begin
                if (col_pos > 0) col_pos--;
            end
        end else begin
            x_ms = xt;
        end
        if (yt >= band_ms(y_band(ys))) begin
            y_ms = '0;
            if (ys < y_up) begin
                if (row_pos < ROW_COUNT - 1) row_pos++;
            end else if (ys > y_down) begin
                if (row_pos > 0) row_pos--;
            end
        end else begin
            y_ms = yt;
        end
        r.column  = 3'(col_pos);
        r.row     = 3'(row_pos);
        r.pattern = (col_pos < 8) ? 8'(1 << col_pos) : 8'd0;
        return r;
    endfunction

    always @(posedge i_clk) begin
        t_dot_result want;
        if (!i_rst_n) begin
            x_left  = 10'd386;
            x_right = 10'd447;
            y_up    = 10'd416;
            y_down  = 10'd480;
            x_ms    = '0;
            y_ms    = '0;
            col_pos = 0;
            row_pos = 0;
            expected_dots.delete();
        end else begin
            if (i_cfg_we) begin
                case (t_cfg_reg'(i_cfg_index))
                    CFG_X_LEFT:  x_left  = i_cfg_data;
                    CFG_X_RIGHT: x_right = i_cfg_data;
                    CFG_Y_UP:    y_up    = i_cfg_data;
                    CFG_Y_DOWN:  y_down  = i_cfg_data;
                    default: ;
                endcase
            end
            // check the result side before queuing this edge's tick
            if (i_out_mon.valid && i_out_mon.ready) begin
                if (expected_dots.size() == 0) begin
                    report_mismatch($sformatf("result with none expected: col %0d row %0d pat %02h",
                                              i_out_mon.dot_column, i_out_mon.dot_row,
                                              i_out_mon.column_pattern));
                end else begin
                    want = expected_dots.pop_front();
                    if (i_out_mon.dot_column !== want.column)
                        report_mismatch($sformatf("dot_column expected %0d got %0d",
                                                  want.column, i_out_mon.dot_column));
                    if (i_out_mon.dot_row !== want.row)
                        report_mismatch($sformatf("dot_row expected %0d got %0d",
                                                  want.row, i_out_mon.dot_row));
                    if (i_out_mon.column_pattern !== want.pattern)
                        report_mismatch($sformatf("column_pattern expected %02h got %02h",
                                                  want.pattern, i_out_mon.column_pattern));
                end
            end
            if (i_in_mon.valid && i_in_mon.ready) begin
                expected_dots.push_back(advance_dot(i_in_mon.x_sample, i_in_mon.y_sample));
            end
        end
        o_pending = expected_dots.size();
    end

endmodule

// ===== sim/joystick_dot_mover_tb.sv =====
`timescale 1ns / 1ps

module joystick_dot_mover_tb;
    import jdm_pkg::*;

    localparam int QUIET_LIMIT = 1000;
    localparam int PHASE_TICKS = 150;
    localparam int PHASES      = 12;

    logic                i_clk = 1'b0;
    logic                i_rst_n;
    logic                i_cfg_we;
    t_cfg_reg            cfg_index;
    logic [SAMPLE_W-1:0] i_cfg_data;

    int fail_count;
    int pending;
    int sender_idle_pct = 0;
    int recv_stall_pct  = 0;
    int quiet_cycles    = 0;

    jdm_in_if  in_ch ();
    jdm_out_if out_ch ();

    always #4 i_clk = ~i_clk;

    joystick_dot_mover uut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_index (cfg_index),
        .i_cfg_data  (i_cfg_data),
        .i_in        (in_ch),
        .o_out       (out_ch)
    );

    dot_track_checker chk (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg_we     (i_cfg_we),
        .i_cfg_index  (cfg_index),
        .i_cfg_data   (i_cfg_data),
        .i_in_mon     (in_ch),
        .i_out_mon    (out_ch),
        .o_fail_count (fail_count),
        .o_pending    (pending)
    );

    always @(negedge i_clk) begin
        out_ch.ready = ($urandom_range(99) >= recv_stall_pct);
    end

    // Watchdog: too long without any transfer means the block hung
    always @(posedge i_clk) begin
        if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) begin
            quiet_cycles = 0;
        end else begin
            quiet_cycles++;
            if (quiet_cycles >= QUIET_LIMIT) begin
                $display("*** FAILED ***");
                $finish;
            end
        end
    end

    // Called at a falling edge; returns at the falling edge after the transfer
    task automatic send_tick(input logic [SAMPLE_W-1:0] xs, input logic [SAMPLE_W-1:0] ys);
        if ($urandom_range(99) < sender_idle_pct) begin
            in_ch.valid = 1'b0;
            repeat ($urandom_range(1, 4)) @(negedge i_clk);
        end
        in_ch.valid    = 1'b1;
        in_ch.x_sample = xs;
        in_ch.y_sample = ys;
        do @(posedge i_clk); while (!in_ch.ready);
        @(negedge i_clk);
    endtask

    task automatic wait_drained();
        in_ch.valid = 1'b0;
        while (pending != 0) @(negedge i_clk);
    endtask

    // Drain, let the pipeline settle, then write all four limits
    task automatic set_limits(input logic [SAMPLE_W-1:0] xl, input logic [SAMPLE_W-1:0] xr,
                              input logic [SAMPLE_W-1:0] yu, input logic [SAMPLE_W-1:0] yd);
        wait_drained();
        repeat (3) @(negedge i_clk);
        i_cfg_we = 1'b1;
        cfg_index = CFG_X_LEFT;  i_cfg_data = xl; @(negedge i_clk);
        cfg_index = CFG_X_RIGHT; i_cfg_data = xr; @(negedge i_clk);
        cfg_index = CFG_Y_UP;    i_cfg_data = yu; @(negedge i_clk);
        cfg_index = CFG_Y_DOWN;  i_cfg_data = yd; @(negedge i_clk);
        i_cfg_we = 1'b0;
    endtask

    function automatic logic [SAMPLE_W-1:0] pick_sample();
        case ($urandom_range(4))
            0:       return SAMPLE_W'($urandom_range(1023));
            1:       return SAMPLE_W'($urandom_range(60));
            2:       return SAMPLE_W'($urandom_range(1023, 880));
            3:       return SAMPLE_W'($urandom_range(120, 330));
            default: return SAMPLE_W'($urandom_range(590, 820));
        endcase
    endfunction

    initial begin
        int sent;
        int hold;
        logic [SAMPLE_W-1:0] xs;
        logic [SAMPLE_W-1:0] ys;
        logic [SAMPLE_W-1:0] lim_a;
        logic [SAMPLE_W-1:0] lim_b;

        i_rst_n         = 1'b0;
        i_cfg_we        = 1'b0;
        cfg_index       = CFG_X_LEFT;
        i_cfg_data      = '0;
        in_ch.valid     = 1'b0;
        in_ch.x_sample  = '0;
        in_ch.y_sample  = '0;
        repeat (2) @(negedge i_clk);
        i_rst_n = 1'b1;

        // Full deflection until both axes pin at the grid edge
        repeat (8) send_tick(10'd0, 10'd0);
        send_tick(10'd1023, 10'd1023);
        // Band edges on both axes
        send_tick(10'd48,  10'd133);
        send_tick(10'd49,  10'd134);
        send_tick(10'd225, 10'd220);
        send_tick(10'd226, 10'd221);
        send_tick(10'd379, 10'd320);
        send_tick(10'd380, 10'd321);
        send_tick(10'd407, 10'd594);
        send_tick(10'd408, 10'd595);
        send_tick(10'd657, 10'd695);
        send_tick(10'd658, 10'd696);
        send_tick(10'd899, 10'd797);
        send_tick(10'd900, 10'd798);
        // Crossed limits: a mid sample passes both, the lower-limit step wins
        set_limits(10'd900, 10'd100, 10'd900, 10'd100);
        send_tick(10'd500, 10'd500);
        send_tick(10'd20,  10'd20);
        send_tick(10'd1023, 10'd1023);

        for (int phase = 0; phase < PHASES; phase++) begin
            case (phase % 6)
                0: set_limits(10'd386, 10'd447, 10'd416, 10'd480);
                1: set_limits(10'd0, 10'd0, 10'd0, 10'd0);
                2: set_limits(10'd1023, 10'd1023, 10'd1023, 10'd1023);
                3: set_limits(10'd1023, 10'd0, 10'd700, 10'd300);
                4: set_limits(SAMPLE_W'($urandom_range(1023)), SAMPLE_W'($urandom_range(1023)),
                              SAMPLE_W'($urandom_range(1023)), SAMPLE_W'($urandom_range(1023)));
                default: begin
                    lim_a = SAMPLE_W'($urandom_range(300, 500));
                    lim_b = SAMPLE_W'($urandom_range(500, 700));
                    set_limits(lim_a, lim_b, lim_a, lim_b);
                end
            endcase
            case (phase % 4)
                0: begin sender_idle_pct = 0;  recv_stall_pct = 0;  end
                1: begin sender_idle_pct = 45; recv_stall_pct = 0;  end
                2: begin sender_idle_pct = 0;  recv_stall_pct = 45; end
                default: begin sender_idle_pct = 7; recv_stall_pct = 7; end
            endcase
            sent = 0;
            while (sent < PHASE_TICKS) begin
                xs = pick_sample();
                ys = pick_sample();
                // Mostly held stick positions so the timers reach their periods
                hold = ($urandom_range(7) == 0) ? 1 : $urandom_range(2, 12);
                for (int k = 0; k < hold && sent < PHASE_TICKS; k++) begin
                    send_tick(xs, ys);
                    sent++;
                    if (phase == 5 && sent % 40 == 0) wait_drained();
                end
            end
        end

        wait_drained();
        repeat (4) @(posedge i_clk);
        if (fail_count == 0) begin
            $display("*** PASSED ***");
        end else begin
            $display("*** FAILED ***");
        end
        $finish;
    end

endmodule

// ===== joystick_dot_mover.f =====
design/jdm_pkg.sv
design/jdm_in_if.sv
design/jdm_out_if.sv
design/jdm_decode.sv
design/jdm_update.sv
design/joystick_dot_mover.sv
sim/dot_track_checker.sv
sim/joystick_dot_mover_tb.sv
